// ----- design/md5_pkg.sv -----
// Shared types, constants and small functions of the MD5 digest block.
// Used by md5_front, md5_cmd_queue, md5_back and md5_message_digest.
// No dependencies.
package md5_pkg;

   // initial chaining vector
   localparam logic [31:0] IvA = 32'h67452301;
   localparam logic [31:0] IvB = 32'hefcdab89;
   localparam logic [31:0] IvC = 32'h98badcfe;
   localparam logic [31:0] IvD = 32'h10325476;

   // padding marker and the byte position where the length starts
   localparam logic [7:0] PadByte  = 8'h80;
   localparam logic [5:0] LenStart = 6'd56;

   // block buffer: two banks of sixteen 32-bit words
   localparam int WordsPerBlock = 16;
   localparam int BufWords      = 2 * WordsPerBlock;
   localparam int BufAddrW      = $clog2(BufWords);

   localparam logic [31:0] RoundConst [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};

   // rotate amounts, indexed by {round group, round mod 4}
   localparam logic [4:0] ShiftAmt [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22,
      5'd5, 5'd9,  5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23,
      5'd6, 5'd10, 5'd15, 5'd21};

   // round groups
   localparam logic [1:0] GrpF = 2'd0;
   localparam logic [1:0] GrpG = 2'd1;
   localparam logic [1:0] GrpH = 2'd2;
   localparam logic [1:0] GrpI = 2'd3;

   // job handed from the front to the round unit
   typedef struct packed {
      logic bank;
      logic last_blk;
   } cmd_type;

   // bank handed back once its words are consumed
   typedef struct packed {
      logic valid;
      logic bank;
   } release_type;

   // message word used in a round
   function automatic logic [3:0] round_word(input logic [5:0] rnd);
      logic [3:0] x;
      logic [3:0] k;
      x = rnd[3:0];
      case (rnd[5:4])
         GrpF: k = x;
         GrpG: k = 4'(x * 4'd5 + 4'd1);
         GrpH: k = 4'(x * 4'd3 + 4'd5);
         GrpI: k = 4'(x * 4'd7);
         default: k = x;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] round_shift(input logic [5:0] rnd);
      return ShiftAmt[{rnd[5:4], rnd[1:0]}];
   endfunction

endpackage

// ----- design/md5_cmd_queue.sv -----
// Two-entry queue of block jobs between the front and the round unit.
// Depends on md5_pkg for the job type.
module md5_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  md5_pkg::cmd_type  push_cmd,
   input  logic              pop,
   output logic              head_valid,
   output md5_pkg::cmd_type  head_cmd
);

   md5_pkg::cmd_type slot_ff [2];
   logic             rd_ptr_ff, rd_ptr_in;
   logic             wr_ptr_ff, wr_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign head_valid = (count_ff != 2'd0);
   assign head_cmd   = slot_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      do_push   = push && (count_ff != 2'd2);
      do_pop    = pop && head_valid;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload slots
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- design/md5_front.sv -----
// Input side: packs message bytes into words of a two-bank block buffer,
// counts bytes, pads the message end and posts block jobs. Uses md5_pkg.
module md5_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [7:0]                   req_tdata,   // data_byte
   input  logic                         req_tuser,   // has_byte
   input  logic                         req_tlast,   // end_of_message
   output logic                         cmd_push,
   output md5_pkg::cmd_type             cmd,
   input  md5_pkg::release_type         rel,
   input  logic [md5_pkg::BufAddrW-1:0] rd_addr,
   output logic [31:0]                  rd_data
);

   typedef enum logic {ST_IDLE, ST_PAD} state_type;

   state_type   state_ff, state_in;
   logic        bank_ff, bank_in;
   logic [1:0]  busy_ff, busy_in;
   logic [60:0] count_ff, count_in;
   logic [31:0] part_ff, part_in;
   logic [3:0]  widx_ff, widx_in;
   logic [1:0]  lane_ff, lane_in;
   logic        first_ff, first_in;
   logic        fin_ff, fin_in;
   logic [63:0] len_ff, len_in;
   logic [31:0] wbuf_ff [md5_pkg::BufWords];
   logic [31:0] rdata_ff;

   logic                         accept;
   logic [5:0]                   pos;
   logic [60:0]                  next_count;
   logic                         wr_en;
   logic [md5_pkg::BufAddrW-1:0] wr_addr;
   logic [31:0]                  wr_data;
   logic [31:0]                  keep_mask;
   logic [31:0]                  pad_word;

   assign req_tready = (state_ff == ST_IDLE) && !busy_ff[bank_ff];
   assign accept     = req_tvalid && req_tready;
   assign pos        = count_ff[5:0];
   assign rd_data    = rdata_ff;

   // word written while padding
   always_comb begin
      keep_mask = 32'h0;
      for (int j = 0; j < 3; j++) begin
         if (2'(j) < lane_ff) begin
            keep_mask[8*j +: 8] = 8'hff;
         end
      end
      if (first_ff) begin
         pad_word = (part_ff & keep_mask) | (32'(md5_pkg::PadByte) << {lane_ff, 3'b000});
      end else if (fin_ff && (widx_ff == 4'd14)) begin
         pad_word = len_ff[31:0];
      end else if (fin_ff && (widx_ff == 4'd15)) begin
         pad_word = len_ff[63:32];
      end else begin
         pad_word = 32'h0;
      end
   end

   // byte packing, padding sequencer and bank ownership
   always_comb begin
      state_in   = state_ff;
      bank_in    = bank_ff;
      busy_in    = busy_ff;
      count_in   = count_ff;
      part_in    = part_ff;
      widx_in    = widx_ff;
      lane_in    = lane_ff;
      first_in   = first_ff;
      fin_in     = fin_ff;
      len_in     = len_ff;
      wr_en      = 1'b0;
      wr_addr    = {bank_ff, pos[5:2]};
      wr_data    = part_ff;
      cmd_push   = 1'b0;
      cmd        = '{bank: bank_ff, last_blk: 1'b0};
      next_count = count_ff;

      if (rel.valid) begin
         busy_in[rel.bank] = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept && req_tuser) begin
               part_in[8*pos[1:0] +: 8] = req_tdata;
               next_count = count_ff + 61'd1;
               count_in   = next_count;
               if (pos[1:0] == 2'd3) begin
                  wr_en   = 1'b1;
                  wr_data = part_in;
               end
               if (pos == 6'd63) begin
                  cmd_push         = 1'b1;
                  busy_in[bank_ff] = 1'b1;
                  bank_in          = ~bank_ff;
               end
            end
            if (accept && req_tlast) begin
               state_in = ST_PAD;
               widx_in  = next_count[5:2];
               lane_in  = next_count[1:0];
               first_in = 1'b1;
               fin_in   = (next_count[5:0] < md5_pkg::LenStart);
               len_in   = {next_count, 3'b000};
               count_in = 61'd0;
            end
         end
         ST_PAD: begin
            if (!busy_ff[bank_ff]) begin
               wr_en    = 1'b1;
               wr_addr  = {bank_ff, widx_ff};
               wr_data  = pad_word;
               first_in = 1'b0;
               widx_in  = widx_ff + 4'd1;
               if (widx_ff == 4'd15) begin
                  cmd_push         = 1'b1;
                  cmd.last_blk     = fin_ff;
                  busy_in[bank_ff] = 1'b1;
                  bank_in          = ~bank_ff;
                  fin_in           = 1'b1;
                  if (fin_ff) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         bank_ff  <= 1'b0;
         busy_ff  <= 2'b00;
         count_ff <= 61'd0;
         first_ff <= 1'b0;
         fin_ff   <= 1'b0;
         widx_ff  <= 4'd0;
         lane_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         bank_ff  <= bank_in;
         busy_ff  <= busy_in;
         count_ff <= count_in;
         first_ff <= first_in;
         fin_ff   <= fin_in;
         widx_ff  <= widx_in;
         lane_ff  <= lane_in;
      end
   end

   // payload: partial word, length, buffer and registered read
   always_ff @(posedge clock) begin
      part_ff  <= part_in;
      len_ff   <= len_in;
      rdata_ff <= wbuf_ff[rd_addr];
      if (wr_en) begin
         wbuf_ff[wr_addr] <= wr_data;
      end
   end

endmodule

// ----- design/md5_back.sv -----
// Round unit: runs the 64 MD5 rounds of a queued block, one per cycle,
// folds into the chaining words and sends the digest bytes. Uses md5_pkg.
module md5_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         cmd_valid,
   input  md5_pkg::cmd_type             cmd,
   output logic                         cmd_pop,
   output md5_pkg::release_type         rel,
   output logic [md5_pkg::BufAddrW-1:0] rd_addr,
   input  logic [31:0]                  rd_data,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [7:0]                   rsp_tdata,   // digest_byte
   output logic                         rsp_tlast    // digest_last
);

   typedef enum logic [2:0] {ST_IDLE, ST_FETCH, ST_ROUND, ST_ADD, ST_EMIT} state_type;

   state_type   state_ff, state_in;
   logic [5:0]  rnd_ff, rnd_in;
   logic        bank_ff, bank_in;
   logic        fin_ff, fin_in;
   logic [3:0]  idx_ff, idx_in;
   logic [31:0] ca_ff, cb_ff, cc_ff, cd_ff;
   logic [31:0] ca_in, cb_in, cc_in, cd_in;
   logic [31:0] wa_ff, wb_ff, wc_ff, wd_ff;
   logic [31:0] wa_in, wb_in, wc_in, wd_in;
   logic        vld_ff, vld_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;

   logic [31:0]  fun;
   logic [31:0]  tsum;
   logic [63:0]  rot_dbl;
   logic [127:0] digest;
   logic [5:0]   rd_rnd;

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tlast  = last_ff;
   assign cmd_pop    = (state_ff == ST_IDLE) && cmd_valid;
   assign rel        = '{valid: (state_ff == ST_ADD), bank: bank_ff};
   assign digest     = {cd_ff, cc_ff, cb_ff, ca_ff};

   // word for the coming round, addressed in the cycle before it is used
   assign rd_rnd  = (state_ff == ST_ROUND) ? rnd_ff + 6'd1 : 6'd0;
   assign rd_addr = {bank_ff, md5_pkg::round_word(rd_rnd)};

   // one round
   always_comb begin
      case (rnd_ff[5:4])
         md5_pkg::GrpF: fun = (wb_ff & wc_ff) | (~wb_ff & wd_ff);
         md5_pkg::GrpG: fun = (wd_ff & wb_ff) | (~wd_ff & wc_ff);
         md5_pkg::GrpH: fun = wb_ff ^ wc_ff ^ wd_ff;
         md5_pkg::GrpI: fun = wc_ff ^ (wb_ff | ~wd_ff);
         default:       fun = 32'h0;
      endcase
      tsum    = fun + wa_ff + md5_pkg::RoundConst[rnd_ff] + rd_data;
      rot_dbl = {32'h0, tsum} << md5_pkg::round_shift(rnd_ff);
      rot_dbl = {rot_dbl[63:32] | rot_dbl[31:0], 32'h0};
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      rnd_in   = rnd_ff;
      bank_in  = bank_ff;
      fin_in   = fin_ff;
      idx_in   = idx_ff;
      ca_in    = ca_ff;
      cb_in    = cb_ff;
      cc_in    = cc_ff;
      cd_in    = cd_ff;
      wa_in    = wa_ff;
      wb_in    = wb_ff;
      wc_in    = wc_ff;
      wd_in    = wd_ff;
      vld_in   = vld_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               bank_in  = cmd.bank;
               fin_in   = cmd.last_blk;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            wa_in    = ca_ff;
            wb_in    = cb_ff;
            wc_in    = cc_ff;
            wd_in    = cd_ff;
            rnd_in   = 6'd0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            wa_in  = wd_ff;
            wd_in  = wc_ff;
            wc_in  = wb_ff;
            wb_in  = wb_ff + rot_dbl[63:32];
            rnd_in = rnd_ff + 6'd1;
            if (rnd_ff == 6'd63) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            ca_in = ca_ff + wa_ff;
            cb_in = cb_ff + wb_ff;
            cc_in = cc_ff + wc_ff;
            cd_in = cd_ff + wd_ff;
            if (fin_ff) begin
               vld_in   = 1'b1;
               byte_in  = ca_in[7:0];
               last_in  = 1'b0;
               idx_in   = 4'd0;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (rsp_tready) begin
               if (idx_ff == 4'd15) begin
                  vld_in   = 1'b0;
                  ca_in    = md5_pkg::IvA;
                  cb_in    = md5_pkg::IvB;
                  cc_in    = md5_pkg::IvC;
                  cd_in    = md5_pkg::IvD;
                  state_in = ST_IDLE;
               end else begin
                  idx_in  = idx_ff + 4'd1;
                  byte_in = digest[{idx_in, 3'b000} +: 8];
                  last_in = (idx_in == 4'd15);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         vld_ff   <= 1'b0;
         ca_ff    <= md5_pkg::IvA;
         cb_ff    <= md5_pkg::IvB;
         cc_ff    <= md5_pkg::IvC;
         cd_ff    <= md5_pkg::IvD;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
         ca_ff    <= ca_in;
         cb_ff    <= cb_in;
         cc_ff    <= cc_in;
         cd_ff    <= cd_in;
      end
   end

   // working and output payload
   always_ff @(posedge clock) begin
      rnd_ff  <= rnd_in;
      bank_ff <= bank_in;
      fin_ff  <= fin_in;
      idx_ff  <= idx_in;
      wa_ff   <= wa_in;
      wb_ff   <= wb_in;
      wc_ff   <= wc_in;
      wd_ff   <= wd_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

endmodule

// ----- design/md5_message_digest.sv -----
// Top level of the MD5 digest block: front packer, job queue, round unit.
// Depends on md5_pkg, md5_front, md5_cmd_queue and md5_back.
//
// Send the message one byte per word on req_ (tuser high when tdata holds a
// byte) and mark the final word with tlast; a tlast word with tuser low ends
// the message without a byte, which also covers the empty message. Bytes are
// taken at one per cycle, while the current bank is free, into a two-bank
// block buffer; each full 64-byte block then runs in the round unit through
// job pop, first word fetch, 64 rounds at one per cycle and the fold into
// the chaining words, so on long messages input waits once both banks are
// full. At the end of a message the front writes the padding one word per
// cycle while its bank is free (the rest of the current block, up to 16
// words, plus a full 16-word block when the length spills into a second
// block), the last block or two are compressed, and the 16 digest bytes
// leave on rsp_, chain A low byte first, tlast on the sixteenth. Input is
// held off during padding. No memory clearing is needed after reset.
module md5_message_digest (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tuser,   // [0] has_byte
   input  logic       req_tlast,   // end_of_message
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] digest_byte
   output logic       rsp_tlast    // digest_last
);

   logic                         push;
   md5_pkg::cmd_type             push_cmd;
   logic                         head_valid;
   md5_pkg::cmd_type             head_cmd;
   logic                         pop;
   md5_pkg::release_type         rel;
   logic [md5_pkg::BufAddrW-1:0] rd_addr;
   logic [31:0]                  rd_data;

   md5_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .cmd_push   (push),
      .cmd        (push_cmd),
      .rel        (rel),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data)
   );

   md5_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   md5_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (head_valid),
      .cmd        (head_cmd),
      .cmd_pop    (pop),
      .rel        (rel),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
